/* src/tail_drop_packet_queue_defines.svh */
// Assertion macros shared by the checker of the tail-drop packet queue.
`ifndef TAIL_DROP_PACKET_QUEUE_DEFINES_SVH
`define TAIL_DROP_PACKET_QUEUE_DEFINES_SVH

// Same-cycle implication, sampled on clk and switched off while arst_n is low.
`define TDPQ_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and switched off while arst_n is low.
`define TDPQ_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/tdpq_pkg.sv */
// Shared types, codes and constants of the tail-drop packet queue.
package tdpq_pkg;

	localparam int QUEUE_DEPTH = 64;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		OP_ENQ   = 2'd0,
		OP_DEQ   = 2'd1,
		OP_STATS = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		OUT_ENQ   = 3'd0,
		OUT_DROP  = 3'd1,
		OUT_DEQ   = 3'd2,
		OUT_EMPTY = 3'd3,
		OUT_STATS = 3'd4
	} outcome_t;

	localparam logic [1:0] REG_PKT_LIMIT     = 2'd0;
	localparam logic [1:0] REG_BYTE_LIMIT    = 2'd1;
	localparam logic [1:0] REG_INTERVAL_MODE = 2'd2;

	typedef struct packed {
		logic [6:0]  pkt_limit;
		logic [19:0] byte_limit;
		logic        interval_mode;
	} cfg_t;

	// Request payload, lowest field last.
	typedef struct packed {
		logic [1:0]  pad;
		logic [15:0] pkt_tag;
		logic [13:0] pkt_len;
	} in_data_t;

	// Result payload, lowest field last.
	typedef struct packed {
		logic [6:0]  pad;
		logic [47:0] sum_drop_bytes;
		logic [47:0] sum_occ_bytes;
		logic [31:0] sum_occ_pkts;
		logic [19:0] occ_bytes;
		logic [6:0]  occ_pkts;
		logic [13:0] out_len;
		logic [15:0] out_tag;
	} out_data_t;

	typedef struct packed {
		logic [15:0] tag;
		logic [13:0] len;
	} desc_t;

	localparam int DESC_W = $bits(desc_t);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic accept;
		logic finish;
	} ctrl_cmd_t;

	typedef struct packed {
		logic deq_hit;
		logic discard;
	} dp_status_t;

endpackage

/* src/tail_drop_packet_queue.sv */
// Top level of the tail-drop packet queue: configuration registers and module wiring.
//
// Requests arrive on the s_ stream: s_tuser carries the operation (enqueue, dequeue,
// report-and-clear of the interval sums, or the unused code, which is swallowed with no
// result). s_tdata carries the packet length and tag used by an enqueue.
// Every other request yields exactly one result on the m_ stream: m_tuser carries the
// outcome and m_tdata the tag and length concerned, the occupancy after the action and,
// on a stats report, the three interval sums.
// The block handles one request at a time. An enqueue, a stats report or a dequeue on an
// empty queue is accepted and its result is offered in the next cycle; a dequeue
// that hits first passes through the read state for the registered descriptor memory read.
// Once the result is taken, s_tready rises again in the following cycle, so a request
// holds the block through the idle, read (on a hit) and result states when m_tready is high.
// The descriptor memory read port and the controller's single result register set this.
// While the receiver holds m_tready low the result stays registered and unchanged, and
// s_tready stays low, so no request is lost.
// Reset clears pointers, occupancy, interval sums and the limit registers; the memory
// needs no clearing because only written entries are ever read.
// The limit registers are written over the APB port at byte addresses 0, 4 and 8.
module tail_drop_packet_queue import tdpq_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	// Request stream.
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [31:0]  s_tdata,  // [13:0] pkt_len, [29:14] pkt_tag, [31:30] zero
	input  logic [1:0]   s_tuser,  // [1:0] op
	// Result stream.
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [191:0] m_tdata,  // [15:0] out_tag, [29:16] out_len, [36:30] occ_pkts,
	                               // [56:37] occ_bytes, [88:57] sum_occ_pkts,
	                               // [136:89] sum_occ_bytes, [184:137] sum_drop_bytes,
	                               // [191:185] zero
	output logic [2:0]   m_tuser,  // [2:0] outcome
	// Configuration port.
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	cfg_t             cfg_q;
	ctrl_cmd_t        cmd;
	dp_status_t       status;
	in_data_t         in_d;
	out_data_t        res_data;
	logic             ram_we;
	logic             ram_re;
	logic [PTR_W-1:0] ram_waddr;
	logic [PTR_W-1:0] ram_raddr;
	desc_t            ram_wdata;
	desc_t            ram_rdata;

	// The port never inserts wait states.
	assign pready = 1'b1;

	// Register writes land on the access phase; the word index is taken from paddr[3:2].
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[3:2])
				REG_PKT_LIMIT:     cfg_q.pkt_limit     <= pwdata[6:0];
				REG_BYTE_LIMIT:    cfg_q.byte_limit    <= pwdata[19:0];
				REG_INTERVAL_MODE: cfg_q.interval_mode <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_PKT_LIMIT:     prdata = 32'(cfg_q.pkt_limit);
			REG_BYTE_LIMIT:    prdata = 32'(cfg_q.byte_limit);
			REG_INTERVAL_MODE: prdata = 32'(cfg_q.interval_mode);
			default:           prdata = '0;
		endcase
	end

	assign in_d = in_data_t'(s_tdata);

	tdpq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	tdpq_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.cfg         (cfg_q),
		.in_op       (s_tuser),
		.in_len      (in_d.pkt_len),
		.in_tag      (in_d.pkt_tag),
		.ram_we      (ram_we),
		.ram_waddr   (ram_waddr),
		.ram_wdata   (ram_wdata),
		.ram_re      (ram_re),
		.ram_raddr   (ram_raddr),
		.ram_rdata   (ram_rdata),
		.res_data    (res_data),
		.res_outcome (m_tuser)
	);

	// Descriptor memory: one entry per queued packet, written at the tail, read at the head.
	tdpq_ram #(
		.WIDTH (DESC_W),
		.DEPTH (QUEUE_DEPTH)
	) u_desc_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign m_tdata = res_data;

endmodule

/* src/tdpq_ram.sv */
// Generic single-port-write, registered-read RAM.
module tdpq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* src/tdpq_ctrl.sv */
// Controller state machine of the tail-drop packet queue.
module tdpq_ctrl import tdpq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	output logic       m_tvalid,
	input  logic       m_tready,
	input  dp_status_t status,
	output ctrl_cmd_t  cmd
);

	state_t state_q;
	state_t state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n    = state_q;
		s_tready   = 1'b0;
		m_tvalid   = 1'b0;
		cmd.accept = 1'b0;
		cmd.finish = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					if (status.discard) begin
						state_n = ST_IDLE;
					end else if (status.deq_hit) begin
						state_n = ST_READ;
					end else begin
						state_n = ST_RESP;
					end
				end
			end
			ST_READ: begin
				cmd.finish = 1'b1;
				state_n    = ST_RESP;
			end
			ST_RESP: begin
				m_tvalid = 1'b1;
				if (m_tready) begin
					state_n = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

endmodule

/* src/tdpq_dp.sv */
// Datapath of the tail-drop packet queue: pointers, occupancy, interval sums, result register.
module tdpq_dp import tdpq_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  ctrl_cmd_t         cmd,
	output dp_status_t        status,
	input  cfg_t              cfg,
	input  logic [1:0]        in_op,
	input  logic [13:0]       in_len,
	input  logic [15:0]       in_tag,
	output logic              ram_we,
	output logic [PTR_W-1:0]  ram_waddr,
	output desc_t             ram_wdata,
	output logic              ram_re,
	output logic [PTR_W-1:0]  ram_raddr,
	input  desc_t             ram_rdata,
	output out_data_t         res_data,
	output logic [2:0]        res_outcome
);

	function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? '1 : s[31:0];
	endfunction

	function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [47:0] b);
		logic [48:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[48] ? '1 : s[47:0];
	endfunction

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	logic [PTR_W-1:0] head_q, head_n;
	logic [PTR_W-1:0] tail_q, tail_n;
	logic [CNT_W-1:0] count_q, count_n;
	logic [19:0]      bytes_q, bytes_n;
	logic [31:0]      acc_pkts_q, acc_pkts_n;
	logic [47:0]      acc_bytes_q, acc_bytes_n;
	logic [47:0]      acc_drops_q, acc_drops_n;
	out_data_t        out_q, out_n;
	outcome_t         outcome_q, outcome_n;

	logic [20:0] byte_sum;
	logic        refuse;
	op_t         op;

	assign op             = op_t'(in_op);
	assign status.deq_hit = (op == OP_DEQ) && (count_q != '0);
	assign status.discard = (op == OP_NONE);

	// Admission: configured limits, then the hardware limits of the store and the byte counter.
	assign byte_sum = {1'b0, bytes_q} + 21'(in_len);
	always_comb begin
		refuse = 1'b0;
		if ((cfg.pkt_limit != '0) && (32'(count_q) >= 32'(cfg.pkt_limit))) begin
			refuse = 1'b1;
		end
		if ((cfg.byte_limit != '0) && (byte_sum > 21'(cfg.byte_limit))) begin
			refuse = 1'b1;
		end
		if (32'(count_q) >= QUEUE_DEPTH) begin
			refuse = 1'b1;
		end
		if (byte_sum[20]) begin
			refuse = 1'b1;
		end
	end

	assign ram_waddr = tail_q;
	assign ram_raddr = head_q;
	assign ram_wdata = '{tag: in_tag, len: in_len};

	always_comb begin
		head_n      = head_q;
		tail_n      = tail_q;
		count_n     = count_q;
		bytes_n     = bytes_q;
		acc_pkts_n  = acc_pkts_q;
		acc_bytes_n = acc_bytes_q;
		acc_drops_n = acc_drops_q;
		out_n       = out_q;
		outcome_n   = outcome_q;
		ram_we      = 1'b0;
		ram_re      = 1'b0;
		if (cmd.accept) begin
			out_n = '0;
			case (op)
				OP_ENQ: begin
					if (refuse) begin
						outcome_n     = OUT_DROP;
						out_n.out_tag = in_tag;
						out_n.out_len = in_len;
						if (cfg.interval_mode) begin
							acc_drops_n = sat_add48(acc_drops_q, 48'(in_len));
						end
					end else begin
						outcome_n = OUT_ENQ;
						ram_we    = 1'b1;
						tail_n    = ptr_inc(tail_q);
						count_n   = count_q + 1'b1;
						bytes_n   = byte_sum[19:0];
						if (cfg.interval_mode) begin
							acc_pkts_n  = sat_add32(acc_pkts_q, 32'(count_n));
							acc_bytes_n = sat_add48(acc_bytes_q, 48'(bytes_n));
						end
					end
				end
				OP_DEQ: begin
					if (count_q == '0) begin
						outcome_n = OUT_EMPTY;
					end else begin
						ram_re = 1'b1;
					end
				end
				OP_STATS: begin
					outcome_n            = OUT_STATS;
					out_n.sum_occ_pkts   = acc_pkts_q;
					out_n.sum_occ_bytes  = acc_bytes_q;
					out_n.sum_drop_bytes = acc_drops_q;
					acc_pkts_n           = '0;
					acc_bytes_n          = '0;
					acc_drops_n          = '0;
				end
				default: begin
					out_n = out_q;
				end
			endcase
			out_n.occ_pkts  = 7'(count_n);
			out_n.occ_bytes = bytes_n;
		end else if (cmd.finish) begin
			// Descriptor read from the head entry has arrived.
			outcome_n       = OUT_DEQ;
			head_n          = ptr_inc(head_q);
			count_n         = count_q - 1'b1;
			bytes_n         = (bytes_q >= 20'(ram_rdata.len)) ? bytes_q - 20'(ram_rdata.len) : '0;
			out_n           = '0;
			out_n.out_tag   = ram_rdata.tag;
			out_n.out_len   = ram_rdata.len;
			out_n.occ_pkts  = 7'(count_n);
			out_n.occ_bytes = bytes_n;
			if (cfg.interval_mode) begin
				acc_pkts_n  = sat_add32(acc_pkts_q, 32'(count_n));
				acc_bytes_n = sat_add48(acc_bytes_q, 48'(bytes_n));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			bytes_q     <= '0;
			acc_pkts_q  <= '0;
			acc_bytes_q <= '0;
			acc_drops_q <= '0;
		end else begin
			head_q      <= head_n;
			tail_q      <= tail_n;
			count_q     <= count_n;
			bytes_q     <= bytes_n;
			acc_pkts_q  <= acc_pkts_n;
			acc_bytes_q <= acc_bytes_n;
			acc_drops_q <= acc_drops_n;
		end
	end

	always_ff @(posedge clk) begin
		out_q     <= out_n;
		outcome_q <= outcome_n;
	end

	assign res_data    = out_q;
	assign res_outcome = outcome_q;

endmodule

/* src/tdpq_checker.sv */
// Port-level checker of the tail-drop packet queue and its bind.
`include "tail_drop_packet_queue_defines.svh"

module tdpq_checker import tdpq_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic [31:0]  s_tdata,
	input logic [1:0]   s_tuser,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [191:0] m_tdata,
	input logic [2:0]   m_tuser,
	input logic         psel,
	input logic         penable,
	input logic         pwrite,
	input logic [3:0]   paddr,
	input logic [31:0]  pwdata,
	input logic [31:0]  prdata,
	input logic         pready
);

	out_data_t m_d;
	logic      enq_acc;

	assign m_d     = out_data_t'(m_tdata);
	assign enq_acc = s_tvalid && s_tready && (s_tuser == OP_ENQ);

	// One request in flight: no new request is taken while a result is offered.
	`TDPQ_ASSERT_IMP(a_one_in_flight, m_tvalid, !s_tready, "request taken while result pending")

	`TDPQ_ASSERT_IMP(a_occ_bound, m_tvalid, 32'(m_d.occ_pkts) <= QUEUE_DEPTH,
		"packet occupancy beyond queue depth")

	`TDPQ_ASSERT_IMP(a_sums_stats_only, m_tvalid && (m_tuser != OUT_STATS),
		(m_d.sum_occ_pkts == '0) && (m_d.sum_occ_bytes == '0) && (m_d.sum_drop_bytes == '0),
		"interval sums shown outside a stats report")

	`TDPQ_ASSERT_NXT(a_enq_latency, enq_acc, m_tvalid, "enqueue result not offered next cycle")

	`TDPQ_ASSERT_NXT(a_result_hold, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

endmodule

bind tail_drop_packet_queue tdpq_checker u_tdpq_checker (.*);

/* bench/tdpq_action_checker.sv */
// Checker for the tail-drop packet queue: predicts each result and compares it.
module tdpq_action_checker import tdpq_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [31:0]  s_tdata,
	input  logic [1:0]   s_tuser,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [191:0] m_tdata,
	input  logic [2:0]   m_tuser,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	input  logic         pready,
	output int           action_faults,
	output int           actions_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [19:0] BYTE_CEIL      = '1;
	localparam logic [47:0] PKTS_SUM_CEIL  = 48'hFFFF_FFFF;
	localparam logic [47:0] WIDE_SUM_CEIL  = '1;
	localparam int          REPORTED_FAULTS = 10;

	typedef struct {
		outcome_t    outcome;
		logic [15:0] tag;
		logic [13:0] len;
		logic [6:0]  occ_pkts;
		logic [19:0] occ_bytes;
		logic [31:0] sum_pkts;
		logic [47:0] sum_bytes;
		logic [47:0] sum_drops;
	} action_t;

	desc_t            slots [QUEUE_DEPTH];
	logic [PTR_W-1:0] rd_ptr;
	logic [PTR_W-1:0] wr_ptr;
	logic [6:0]       pkts_held;
	logic [19:0]      bytes_held;
	logic [31:0]      run_pkts;
	logic [47:0]      run_bytes;
	logic [47:0]      run_drops;
	cfg_t             cfg;
	action_t          expected_actions [$];

	in_data_t  req;
	out_data_t res;

	assign req = in_data_t'(s_tdata);
	assign res = out_data_t'(m_tdata);

	function automatic logic [47:0] add_capped(logic [47:0] acc, logic [47:0] inc,
			logic [47:0] ceil);
		logic [48:0] total;
		total = {1'b0, acc} + {1'b0, inc};
		return (total > {1'b0, ceil}) ? ceil : total[47:0];
	endfunction

	function automatic logic [PTR_W-1:0] ring_next(logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// Occupancy sums only move in interval mode.
	task automatic add_occupancy();
		if (cfg.interval_mode) begin
			run_pkts  = 32'(add_capped(48'(run_pkts), 48'(pkts_held), PKTS_SUM_CEIL));
			run_bytes = add_capped(run_bytes, 48'(bytes_held), WIDE_SUM_CEIL);
		end
	endtask

	task automatic settle_request(input op_t op, input logic [13:0] len,
			input logic [15:0] tag);
		action_t     act;
		logic [20:0] bytes_after;
		logic        refuse;
		desc_t       head;
		act.outcome   = OUT_STATS;
		act.tag       = '0;
		act.len       = '0;
		act.sum_pkts  = '0;
		act.sum_bytes = '0;
		act.sum_drops = '0;
		bytes_after   = {1'b0, bytes_held} + 21'(len);
		if (op != OP_NONE) begin
			case (op)
				OP_ENQ: begin
					refuse = (cfg.pkt_limit != 0 && pkts_held >= cfg.pkt_limit)
						|| (cfg.byte_limit != 0 && bytes_after > 21'(cfg.byte_limit))
						|| (pkts_held >= QUEUE_DEPTH)
						|| (bytes_after > 21'(BYTE_CEIL));
					if (refuse) begin
						act.outcome = OUT_DROP;
						act.tag     = tag;
						act.len     = len;
						if (cfg.interval_mode)
							run_drops = add_capped(run_drops, 48'(len), WIDE_SUM_CEIL);
					end else begin
						slots[wr_ptr] = '{tag: tag, len: len};
						wr_ptr        = ring_next(wr_ptr);
						pkts_held     = pkts_held + 1'b1;
						bytes_held    = bytes_after[19:0];
						act.outcome   = OUT_ENQ;
						add_occupancy();
					end
				end
				OP_DEQ: begin
					if (pkts_held == 0) begin
						act.outcome = OUT_EMPTY;
					end else begin
						head       = slots[rd_ptr];
						rd_ptr     = ring_next(rd_ptr);
						pkts_held  = pkts_held - 1'b1;
						bytes_held = (bytes_held >= 20'(head.len)) ? bytes_held - head.len : '0;
						act.outcome = OUT_DEQ;
						act.tag     = head.tag;
						act.len     = head.len;
						add_occupancy();
					end
				end
				default: begin
					act.outcome   = OUT_STATS;
					act.sum_pkts  = run_pkts;
					act.sum_bytes = run_bytes;
					act.sum_drops = run_drops;
					run_pkts      = '0;
					run_bytes     = '0;
					run_drops     = '0;
				end
			endcase
			act.occ_pkts  = pkts_held;
			act.occ_bytes = bytes_held;
			expected_actions.insert(expected_actions.size(), act);
		end
	endtask

	task automatic check_result();
		action_t exp;
		logic    wrong;
		if (expected_actions.size() == 0) begin
			action_faults++;
			if (action_faults <= REPORTED_FAULTS)
				$display("unexpected result: outcome=%0d tag=%h len=%0d", m_tuser,
					res.out_tag, res.out_len);
		end else begin
			exp   = expected_actions.pop_front();
			wrong = (m_tuser !== exp.outcome) || (res.out_tag !== exp.tag)
				|| (res.out_len !== exp.len) || (res.occ_pkts !== exp.occ_pkts)
				|| (res.occ_bytes !== exp.occ_bytes) || (res.sum_occ_pkts !== exp.sum_pkts)
				|| (res.sum_occ_bytes !== exp.sum_bytes)
				|| (res.sum_drop_bytes !== exp.sum_drops);
			if (wrong) begin
				action_faults++;
				if (action_faults <= REPORTED_FAULTS) begin
					$display("mismatch at %0t: expected outcome=%0d tag=%h len=%0d occ=%0d/%0d",
						$realtime, exp.outcome, exp.tag, exp.len, exp.occ_pkts, exp.occ_bytes);
					$display("  expected sums=%0d/%0d/%0d", exp.sum_pkts, exp.sum_bytes,
						exp.sum_drops);
					$display("  got outcome=%0d tag=%h len=%0d occ=%0d/%0d sums=%0d/%0d/%0d",
						m_tuser, res.out_tag, res.out_len, res.occ_pkts, res.occ_bytes,
						res.sum_occ_pkts, res.sum_occ_bytes, res.sum_drop_bytes);
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr          = '0;
			wr_ptr          = '0;
			pkts_held       = '0;
			bytes_held      = '0;
			run_pkts        = '0;
			run_bytes       = '0;
			run_drops       = '0;
			cfg             = '0;
			action_faults   = 0;
			actions_pending = 0;
			expected_actions.delete();
		end else begin
			// A result accepted now belongs to an earlier request, so it is checked first.
			if (m_tvalid && m_tready)
				check_result();
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_PKT_LIMIT:     cfg.pkt_limit     = pwdata[6:0];
					REG_BYTE_LIMIT:    cfg.byte_limit    = pwdata[19:0];
					REG_INTERVAL_MODE: cfg.interval_mode = pwdata[0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				settle_request(op_t'(s_tuser), req.pkt_len, req.pkt_tag);
			actions_pending = expected_actions.size();
		end
	end

endmodule

/* bench/tail_drop_packet_queue_test.sv */
// Top of the tail-drop packet queue bench: clock, reset, stimulus and verdict.
module tail_drop_packet_queue_test import tdpq_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	// The limit leaves a wide margin over the slowest correct run.
	localparam int LIMIT_CYCLES = 200000;
	// Requests of the unused code give no result, so the block is given QUIET_CYCLES idle
	// cycles beyond the last result before its registers are touched.
	localparam int QUIET_CYCLES = 10;

	logic         clk      = 1'b0;
	logic         arst_n   = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [31:0]  s_tdata  = '0;
	logic [1:0]   s_tuser  = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [191:0] m_tdata;
	logic [2:0]   m_tuser;
	logic         psel     = 1'b0;
	logic         penable  = 1'b0;
	logic         pwrite   = 1'b0;
	logic [3:0]   paddr    = '0;
	logic [31:0]  pwdata   = '0;
	logic [31:0]  prdata;
	logic         pready;

	int action_faults;
	int actions_pending;
	int cycle_count = 0;
	// Random idling on both sides; switched off for the last stretch of the run.
	bit stalls_on   = 1'b1;

	tail_drop_packet_queue u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	tdpq_action_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tuser         (s_tuser),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.m_tuser         (m_tuser),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.pready          (pready),
		.action_faults   (action_faults),
		.actions_pending (actions_pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Result side: mostly ready, with short random stalls. Each step
	// makes exactly one assignment to m_tready, so no stall is cut short by a race.
	initial begin
		forever begin
			@(posedge clk);
			if (stalls_on && $urandom_range(0, 4) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	// One register write: a setup phase, then an access phase that completes at the
	// edge where pready is seen high. The bus is then left idle afterwards so
	// that back-to-back writes never assign psel twice in one step.
	task automatic set_register(input logic [1:0] idx, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input logic [6:0] pkt_limit, input logic [19:0] byte_limit,
			input logic mode);
		set_register(REG_PKT_LIMIT, 32'(pkt_limit));
		set_register(REG_BYTE_LIMIT, 32'(byte_limit));
		set_register(REG_INTERVAL_MODE, 32'(mode));
	endtask

	// Offers one request and returns at the edge where it is taken. An optional gap
	// comes first; the valid is only lowered when such a gap is wanted, so a request
	// that follows straight on keeps tvalid high without a second assignment.
	task automatic push_request(input op_t op, input logic [13:0] len,
			input logic [15:0] tag);
		if (stalls_on && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {2'b00, tag, len};
		do @(posedge clk); while (!s_tready);
	endtask

	// Stops sending and waits until every predicted result has been taken. The first
	// edge lets the checker record the last request before its count is looked at.
	task automatic settle_down();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (actions_pending != 0) @(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	// A run of random requests. enq_pct sets the share of enqueues, so a phase can fill
	// the queue up to its hard depth or drain it; dequeues, stats reports and the odd
	// request of the unused code take the rest. Lengths lean towards the extremes.
	task automatic random_phase(input int enq_pct, input int count);
		int          pick;
		op_t         op;
		logic [13:0] len;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < enq_pct)
				op = OP_ENQ;
			else if (pick < 92)
				op = OP_DEQ;
			else if (pick < 97)
				op = OP_STATS;
			else
				op = OP_NONE;
			case ($urandom_range(0, 7))
				0:       len = '0;
				1:       len = '1;
				2:       len = 14'($urandom_range(0, 255));
				default: len = 14'($urandom_range(0, 16383));
			endcase
			push_request(op, len, 16'($urandom_range(0, 65535)));
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: no limits, no interval sums. A dequeue and a stats report on
		// the empty queue, a request of the unused code with every length and tag bit set, then
		// packets of the smallest and largest length and tag, drained past empty.
		push_request(OP_DEQ, '0, '0);
		push_request(OP_STATS, '0, '0);
		push_request(OP_NONE, '1, '1);
		push_request(OP_ENQ, '0, '0);
		push_request(OP_ENQ, '1, '1);
		push_request(OP_ENQ, 14'd777, 16'h5AA5);
		push_request(OP_DEQ, '0, '0);
		push_request(OP_DEQ, '0, '0);
		push_request(OP_DEQ, '0, '0);
		push_request(OP_DEQ, '0, '0);
		settle_down();

		// Interval mode with tight limits: a drop on the byte limit, a drop on the
		// packet limit, sums reported and cleared, and an empty dequeue that must leave
		// the sums alone.
		configure(7'd2, 20'd20000, 1'b1);
		push_request(OP_ENQ, '1, 16'h1234);
		push_request(OP_ENQ, '1, 16'h4321);
		push_request(OP_ENQ, 14'd100, 16'hBEEF);
		push_request(OP_ENQ, 14'd5, 16'hCAFE);
		push_request(OP_DEQ, '0, '0);
		push_request(OP_STATS, '0, '0);
		push_request(OP_DEQ, '0, '0);
		push_request(OP_DEQ, '0, '0);
		push_request(OP_STATS, '0, '0);
		settle_down();

		// No limits with sums on; halfway the sender holds off until the queue has
		// answered everything it was sent.
		configure('0, '0, 1'b1);
		random_phase(50, 40);
		settle_down();
		random_phase(50, 40);
		settle_down();

		// A packet limit above the hard depth: the queue fills until the hardware
		// itself refuses. Drops here must not touch the sums.
		configure(7'd127, '0, 1'b0);
		random_phase(85, 90);
		settle_down();

		// Largest byte limit with a packet limit equal to the depth, mostly draining.
		configure(7'd64, 20'hFFFFF, 1'b1);
		random_phase(20, 70);
		settle_down();

		// One packet at a time under a byte limit of one full-sized packet.
		configure(7'd1, 20'd16383, 1'b1);
		random_phase(50, 60);
		settle_down();

		// Random settings for the last stretch, run with neither side idling.
		configure(7'($urandom_range(0, 64)), 20'($urandom_range(0, 20'hFFFFF)),
			1'($urandom_range(0, 1)));
		stalls_on = 1'b0;
		random_phase(50, 80);
		settle_down();

		if (action_faults == 0 && actions_pending == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
